// File: rtl/spd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants, codes and item types of the spectrum packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int MAX_BINS    = 512;
	localparam int SMALL_BINS  = 16;
	localparam int BIG_BINS    = (MAX_BINS > SMALL_BINS) ? MAX_BINS : SMALL_BINS;

	// header, mask and time ahead of the counts, tail after them
	localparam int LEAD_BYTES  = 6;
	localparam int TAIL_BYTES  = 2;
	localparam int BANK_BYTES  = 2 * BIG_BINS + LEAD_BYTES + TAIL_BYTES;
	localparam int MAX_BYTES   = 2 * MAX_BINS + LEAD_BYTES + TAIL_BYTES;
	localparam int SMALL_BYTES = 2 * SMALL_BINS + LEAD_BYTES + TAIL_BYTES;

	localparam int MASK_OFF    = 2;
	localparam int TIME_OFF    = 4;
	localparam int CNT_OFF     = LEAD_BYTES;
	localparam int MASK_BITS   = 16;

	localparam int OFF_W  = $clog2(BANK_BYTES);
	localparam int FILL_W = $clog2(BANK_BYTES + 1);
	localparam int SUM_W  = FILL_W + 1;
	localparam int ADDR_W = $clog2(2 * BANK_BYTES);

	// configuration register indexes
	localparam logic [1:0] REG_HEADER = 2'd0;
	localparam logic [1:0] REG_TAIL   = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_CHAN = 2'd1;
	localparam logic [1:0] STAT_BAD_TAIL = 2'd2;
	localparam logic [1:0] STAT_READ     = 2'd3;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
		logic [8:0] bin_index;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  channel;
		logic [15:0] time_ms;
		logic [15:0] bin_count;
	} rsp_item_t;

endpackage

// File: rtl/spectrum_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_packet_deframer
// Byte-stream deframer for fixed-length spectrum packets over a two-bank
// window memory; counts of the latest accepted packet are read back by index.
// ----------------------------------------------------------------------------
// A count read goes through the window read register, then the result register;
//   a push that fills the window blocks new items while its header is read and
//   compared (SQ_HDR), then SQ_MASK and SQ_TIME when header and tail match.
// Throughput: 1 item per cycle otherwise; reads only while results are taken.
// Reset: control and config registers clear at once; the window memory is not
//   cleared and a count read before the first accepted packet is undefined.
module spectrum_packet_deframer import spd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_item_t   req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_item_t   rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [2:0] SQ_IDLE = 3'd0;
	localparam logic [2:0] SQ_READ = 3'd1;
	localparam logic [2:0] SQ_HDR  = 3'd2;
	localparam logic [2:0] SQ_MASK = 3'd3;
	localparam logic [2:0] SQ_TIME = 3'd4;

	function automatic logic [OFF_W-1:0] wrap_off(input logic [SUM_W-1:0] s);
		if (s >= SUM_W'(BANK_BYTES)) begin
			return OFF_W'(s - SUM_W'(BANK_BYTES));
		end
		return OFF_W'(s);
	endfunction

	function automatic logic [ADDR_W-1:0] mem_index(input logic bank,
			input logic [OFF_W-1:0] off);
		return ADDR_W'(off) + (bank ? ADDR_W'(BANK_BYTES) : ADDR_W'(0));
	endfunction

	function automatic logic [4:0] chan_of(input logic [MASK_BITS-1:0] m);
		logic [4:0] c;
		c = '0;
		for (int i = MASK_BITS - 1; i >= 0; i--) begin
			if (m[i]) c = 5'(i + 1);
		end
		return c;
	endfunction

	// window memory: two banks back to back
	logic [7:0] win_mem [2*BANK_BYTES];

	logic [2:0]        seq_q, seq_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [OFF_W-1:0]  ws_q, ws_d;
	logic              bank_q, bank_d;
	logic [OFF_W-1:0]  lstart_q, lstart_d;
	logic              lmode_q, lmode_d;
	logic [15:0]       hdr_q, tail_q;
	logic              mode_q;
	logic [7:0]        prev_q;
	logic [4:0]        ch_q, ch_d;
	logic              tail_ok_s1;
	logic              rng_s1;
	logic [7:0]        rd_a_q, rd_b_q;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	logic              req_fire, push, out_free, full_now, hdr_ok, bad_chan;
	logic [FILL_W-1:0] pkt_size, fill_inc;
	logic              rd_en, rd_bank;
	logic [OFF_W-1:0]  rd_off_a, rd_off_b;
	logic [ADDR_W-1:0] wr_addr;
	logic              in_range;
	logic [SUM_W-1:0]  cnt_base;
	logic              res_vld;
	rsp_item_t         res;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (seq_q == SQ_IDLE) || (seq_q == SQ_READ && out_free);
	assign req_fire  = req_valid && req_ready;
	assign push      = req_fire && (req.op == OP_PUSH);
	assign pkt_size  = mode_q ? FILL_W'(SMALL_BYTES) : FILL_W'(MAX_BYTES);
	assign fill_inc  = fill_q + FILL_W'(1);
	assign full_now  = (fill_inc == pkt_size);
	assign hdr_ok    = ({rd_a_q, rd_b_q} == hdr_q);
	assign bad_chan  = mode_q && (ch_q == 5'd0);
	assign wr_addr   = mem_index(bank_q, wrap_off(SUM_W'(ws_q) + SUM_W'(fill_q)));
	assign in_range  = 32'(req.bin_index) < 32'(lmode_q ? SMALL_BINS : MAX_BINS);
	// out-of-range reads go to offset zero; their data is masked anyway
	assign cnt_base  = in_range ?
		SUM_W'(lstart_q) + SUM_W'(CNT_OFF) + SUM_W'({req.bin_index, 1'b0}) :
		SUM_W'(0);

	always_comb begin
		seq_d    = seq_q;
		fill_d   = fill_q;
		ws_d     = ws_q;
		bank_d   = bank_q;
		lstart_d = lstart_q;
		lmode_d  = lmode_q;
		ch_d     = ch_q;
		rd_en    = 1'b0;
		rd_bank  = bank_q;
		rd_off_a = ws_q;
		rd_off_b = wrap_off(SUM_W'(ws_q) + SUM_W'(1));
		res_vld  = 1'b0;
		res      = '0;

		unique case (seq_q)
			SQ_IDLE: begin
			end
			SQ_READ: begin
				res_vld        = 1'b1;
				res.status     = STAT_READ;
				res.bin_count  = rng_s1 ? {rd_a_q, rd_b_q} : 16'd0;
				if (out_free) seq_d = SQ_IDLE;
			end
			SQ_HDR: begin
				if (!hdr_ok) begin
					ws_d   = wrap_off(SUM_W'(ws_q) + SUM_W'(1));
					fill_d = fill_q - FILL_W'(1);
					seq_d  = SQ_IDLE;
				end else if (!tail_ok_s1) begin
					res_vld    = 1'b1;
					res.status = STAT_BAD_TAIL;
					if (out_free) begin
						ws_d   = wrap_off(SUM_W'(ws_q) + SUM_W'(2));
						fill_d = fill_q - FILL_W'(2);
						seq_d  = SQ_IDLE;
					end
				end else begin
					rd_en    = 1'b1;
					rd_off_a = wrap_off(SUM_W'(ws_q) + SUM_W'(MASK_OFF));
					rd_off_b = wrap_off(SUM_W'(ws_q) + SUM_W'(MASK_OFF + 1));
					seq_d    = SQ_MASK;
				end
			end
			SQ_MASK: begin
				ch_d     = chan_of({rd_a_q, rd_b_q});
				rd_en    = 1'b1;
				rd_off_a = wrap_off(SUM_W'(ws_q) + SUM_W'(TIME_OFF));
				rd_off_b = wrap_off(SUM_W'(ws_q) + SUM_W'(TIME_OFF + 1));
				seq_d    = SQ_TIME;
			end
			SQ_TIME: begin
				res_vld     = 1'b1;
				res.time_ms = {rd_a_q, rd_b_q};
				if (bad_chan) begin
					res.status = STAT_BAD_CHAN;
					if (out_free) begin
						ws_d   = wrap_off(SUM_W'(ws_q) + SUM_W'(pkt_size));
						fill_d = '0;
						seq_d  = SQ_IDLE;
					end
				end else begin
					res.status  = STAT_OK;
					res.channel = ch_q;
					if (out_free) begin
						lstart_d = ws_q;
						lmode_d  = mode_q;
						bank_d   = !bank_q;
						ws_d     = '0;
						fill_d   = '0;
						seq_d    = SQ_IDLE;
					end
				end
			end
			default: begin
				seq_d = SQ_IDLE;
			end
		endcase

		// new item; only taken when no header check is in flight
		if (req_fire) begin
			if (req.op == OP_READ) begin
				rd_en    = 1'b1;
				rd_bank  = !bank_q;
				rd_off_a = wrap_off(cnt_base);
				rd_off_b = wrap_off(cnt_base + SUM_W'(1));
				seq_d    = SQ_READ;
			end else begin
				fill_d = fill_inc;
				if (full_now) begin
					rd_en    = 1'b1;
					rd_off_a = ws_q;
					rd_off_b = wrap_off(SUM_W'(ws_q) + SUM_W'(1));
					seq_d    = SQ_HDR;
				end
			end
		end

		// a new packet length empties the window
		if (cfg_we && cfg_index == REG_MODE && cfg_data[0] != mode_q) begin
			fill_d = '0;
			ws_d   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) win_mem[wr_addr] <= req.data_byte;
		if (rd_en) begin
			rd_a_q <= win_mem[mem_index(rd_bank, rd_off_a)];
			rd_b_q <= win_mem[mem_index(rd_bank, rd_off_b)];
		end
	end

	always_ff @(posedge clk) begin
		ch_q <= ch_d;
		if (push) begin
			prev_q     <= req.data_byte;
			tail_ok_s1 <= ({prev_q, req.data_byte} == tail_q);
		end
		if (req_fire) rng_s1 <= in_range;
		if (res_vld && out_free) rsp_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_IDLE;
			fill_q      <= '0;
			ws_q        <= '0;
			bank_q      <= 1'b0;
			lstart_q    <= '0;
			lmode_q     <= 1'b0;
			hdr_q       <= '0;
			tail_q      <= '0;
			mode_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			seq_q    <= seq_d;
			fill_q   <= fill_d;
			ws_q     <= ws_d;
			bank_q   <= bank_d;
			lstart_q <= lstart_d;
			lmode_q  <= lmode_d;
			if (out_free) rsp_valid_q <= res_vld;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HEADER: hdr_q  <= cfg_data;
					REG_TAIL:   tail_q <= cfg_data;
					REG_MODE:   mode_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= pkt_size)
		else $error("window fill beyond packet size");

	a_start_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ws_q < OFF_W'(BANK_BYTES))
		else $error("window start outside bank");

	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && !out_free) |=> $stable({rd_a_q, rd_b_q}))
		else $error("read data lost while result stalled");

	a_bank_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_TIME && out_free && !bad_chan) |=>
		(bank_q != $past(bank_q) && fill_q == '0))
		else $error("accepted packet did not swap banks");

endmodule

// File: tb/sv/spectrum_packet_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_packet_deframer_tb
// Self-checking bench for the spectrum packet deframer. A scoreboard class
// tracks the window banks, resync and latest packet, and queues the expected
// result of each accepted item that gives one. Stimulus is a directed pass in both bin
// modes, then random phases of framed packets, broken frames, noise and count
// reads, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module spectrum_packet_deframer_tb;
	import spd_pkg::*;

	localparam int         CYCLE_LIMIT   = 1_000_000;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         SETTLE_CYCLES = 16;
	localparam int         RANDOM_ITEMS  = 450;
	localparam int         PHASES        = 5;
	localparam int         MAX_REPORTS   = 50;
	localparam logic [1:0] REG_UNUSED    = 2'd3;

	class deframe_scoreboard;
		logic [7:0]  win [2][BANK_BYTES];
		int unsigned fill;
		int unsigned wstart;
		int unsigned latest_start;
		bit          bank;
		bit          latest_mode;
		bit          mode;
		bit          have_packet;
		logic [15:0] hdr;
		logic [15:0] tl;
		rsp_item_t   expected_q[$];
		int          errors;

		function new();
			foreach (win[b, i])
				win[b][i] = '0;
			fill         = 0;
			wstart       = 0;
			latest_start = 0;
			bank         = 1'b0;
			latest_mode  = 1'b0;
			mode         = 1'b0;
			have_packet  = 1'b0;
			hdr          = '0;
			tl           = '0;
			errors       = 0;
		endfunction

		function logic [15:0] word_at(bit b, int unsigned start, int unsigned off);
			return {win[b][(start + off) % BANK_BYTES], win[b][(start + off + 1) % BANK_BYTES]};
		endfunction

		function logic [4:0] lowest_channel(logic [15:0] mask);
			for (int i = 0; i < MASK_BITS; i++)
				if (mask[i])
					return 5'(i + 1);
			return '0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_HEADER: hdr = val;
				REG_TAIL:   tl = val;
				REG_MODE: begin
					// a real mode change throws away the partial window
					if (val[0] != mode) begin
						fill   = 0;
						wstart = 0;
					end
					mode = val[0];
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("mismatch: %s", msg);
		endtask

		task note_request(req_item_t item);
			rsp_item_t   want;
			int unsigned size;
			int unsigned nbins;
			want = '0;
			if (item.op == OP_READ) begin
				nbins = latest_mode ? SMALL_BINS : MAX_BINS;
				want.status = STAT_READ;
				if (item.bin_index < nbins)
					want.bin_count = word_at(bank ^ 1'b1, latest_start,
						CNT_OFF + 2 * item.bin_index);
				expected_q.push_back(want);
				return;
			end
			win[bank][(wstart + fill) % BANK_BYTES] = item.data_byte;
			fill++;
			size = mode ? SMALL_BYTES : MAX_BYTES;
			if (fill < size)
				return;
			if (word_at(bank, wstart, 0) != hdr) begin
				wstart = (wstart + 1) % BANK_BYTES;
				fill--;
				return;
			end
			if (word_at(bank, wstart, size - TAIL_BYTES) != tl) begin
				wstart = (wstart + 2) % BANK_BYTES;
				fill -= 2;
				want.status = STAT_BAD_TAIL;
				expected_q.push_back(want);
				return;
			end
			want.channel = lowest_channel(word_at(bank, wstart, MASK_OFF));
			want.time_ms = word_at(bank, wstart, TIME_OFF);
			if (mode && want.channel == 0) begin
				wstart = (wstart + size) % BANK_BYTES;
				fill = 0;
				want.status = STAT_BAD_CHAN;
				expected_q.push_back(want);
				return;
			end
			// accepted: the filled bank becomes the readable one
			latest_start = wstart;
			latest_mode  = mode;
			have_packet  = 1'b1;
			bank        ^= 1'b1;
			wstart       = 0;
			fill         = 0;
			want.status  = STAT_OK;
			expected_q.push_back(want);
		endtask

		task check_result(rsp_item_t got);
			rsp_item_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing expected, status %0d", got.status));
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.channel !== want.channel)
				report($sformatf("channel %0d, expected %0d", got.channel, want.channel));
			if (got.time_ms !== want.time_ms)
				report($sformatf("time_ms %h, expected %h", got.time_ms, want.time_ms));
			if (got.bin_count !== want.bin_count)
				report($sformatf("bin_count %h, expected %h", got.bin_count, want.bin_count));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_item_t   req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_item_t   rsp;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	deframe_scoreboard sb = new();
	bit          hold_request;
	bit          gaps_on;
	int          items_sent;
	int          cycles;

	spectrum_packet_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
			if (req_valid && req_ready)
				sb.note_request(req);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: short and long stalls, quiet stretches, one long hold-off
	initial begin
		int  stall_left;
		int  quiet_left;
		int  r;
		bit  hold_done;
		stall_left = 0;
		quiet_left = 0;
		hold_done  = 1'b0;
		rsp_ready  = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_request && !hold_done) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				if (quiet_left > 0) begin
					quiet_left--;
				end else if (stall_left > 0) begin
					stall_left--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 3)
						quiet_left = $urandom_range(50, 200);
					else if (r < 15)
						stall_left = $urandom_range(1, 3);
					else if (r < 17)
						stall_left = $urandom_range(15, 60);
				end
				rsp_ready <= (stall_left == 0);
				@(negedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_mask();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r < 5)
			return 16'h1 << $urandom_range(0, 15);
		return 16'($urandom);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(req_item_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic push_byte(logic [7:0] b);
		req_item_t item;
		item.op        = OP_PUSH;
		item.data_byte = b;
		item.bin_index = 9'($urandom);
		send_item(item);
	endtask

	task automatic read_bin(logic [8:0] idx);
		req_item_t item;
		item.op        = OP_READ;
		item.data_byte = 8'($urandom);
		item.bin_index = idx;
		send_item(item);
	endtask

	task automatic random_read();
		if ($urandom_range(0, 1))
			read_bin(9'($urandom_range(0, SMALL_BINS - 1)));
		else
			read_bin(9'($urandom_range(0, MAX_BINS - 1)));
	endtask

	// one frame in the current mode; cut > 0 sends only its first cut bytes
	task automatic send_packet(input logic [15:0] mask, input logic [15:0] stamp,
			input bit bad_hdr, input bit bad_tail, input bit extreme,
			input int cut, input int read_pct);
		logic [7:0]  frame_q[$];
		logic [15:0] w;
		int          nbins;
		nbins = sb.mode ? SMALL_BINS : MAX_BINS;
		w = sb.hdr;
		if (bad_hdr)
			w ^= 16'h1 << $urandom_range(0, 15);
		frame_q.push_back(w[15:8]);
		frame_q.push_back(w[7:0]);
		frame_q.push_back(mask[15:8]);
		frame_q.push_back(mask[7:0]);
		frame_q.push_back(stamp[15:8]);
		frame_q.push_back(stamp[7:0]);
		for (int i = 0; i < nbins; i++) begin
			w = extreme ? (i[0] ? 16'hFFFF : 16'h0000) : 16'($urandom);
			frame_q.push_back(w[15:8]);
			frame_q.push_back(w[7:0]);
		end
		w = sb.tl;
		if (bad_tail)
			w ^= 16'h1 << $urandom_range(0, 15);
		frame_q.push_back(w[15:8]);
		frame_q.push_back(w[7:0]);
		if (cut > 0)
			while (frame_q.size() > cut)
				void'(frame_q.pop_back());
		foreach (frame_q[i]) begin
			if (sb.have_packet && $urandom_range(0, 99) < read_pct)
				random_read();
			push_byte(frame_q[i]);
		end
	endtask

	// hunting pushes give no result, so let the block settle after the last one
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_regs(input logic [15:0] header, input logic [15:0] tail, input bit bins16);
		logic [15:0] junk;
		logic [15:0] mode_word;
		wait_idle();
		junk = 16'($urandom);
		mode_word = 16'($urandom);
		mode_word[0] = bins16;
		cfg_we    <= 1'b1;
		cfg_index <= REG_HEADER;
		cfg_data  <= header;
		@(negedge clk);
		sb.write_reg(REG_HEADER, header);
		cfg_index <= REG_UNUSED;
		cfg_data  <= junk;
		@(negedge clk);
		sb.write_reg(REG_UNUSED, junk);
		cfg_index <= REG_TAIL;
		cfg_data  <= tail;
		@(negedge clk);
		sb.write_reg(REG_TAIL, tail);
		cfg_index <= REG_MODE;
		cfg_data  <= mode_word;
		@(negedge clk);
		sb.write_reg(REG_MODE, mode_word);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int r;
		int phase_end;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_HEADER;
		cfg_data     = '0;
		hold_request = 1'b0;
		gaps_on      = 1'b1;
		items_sent   = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 16-bin mode: leading noise, both channel extremes, empty mask, bad tail
		set_regs(16'hEB90, 16'h146F, 1'b1);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'hEB);
		send_packet(16'h0001, 16'hFFFF, 1'b0, 1'b0, 1'b1, 0, 0);
		read_bin(9'd0);
		read_bin(9'(SMALL_BINS - 1));
		read_bin(9'(SMALL_BINS));
		read_bin(9'(MAX_BINS - 1));
		send_packet(16'h8000, 16'h0000, 1'b0, 1'b0, 1'b0, 0, 0);
		send_packet(16'h0000, 16'($urandom), 1'b0, 1'b0, 1'b0, 0, 0);
		send_packet(16'h0006, 16'($urandom), 1'b0, 1'b1, 1'b0, 0, 0);
		send_packet(16'hFFFF, 16'($urandom), 1'b0, 1'b0, 1'b1, 0, 0);
		read_bin(9'd0);
		read_bin(9'd7);

		// 512-bin mode: a partial window only; reads still see the last 16-bin packet
		set_regs(16'hFFFF, 16'h0000, 1'b0);
		repeat (30) push_byte(8'($urandom));
		read_bin(9'(MAX_BINS - 1));
		read_bin(9'd0);
		read_bin(9'(SMALL_BINS));
		repeat (6) random_read();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_regs(16'h0000, 16'hFFFF, 1'b1);
				1: set_regs(16'hFFFF, 16'hFFFF, 1'b1);
				2: begin
					// partial 512-bin window, then back to 16 bins
					set_regs(16'($urandom), 16'($urandom), 1'b0);
					repeat (60) push_byte(8'($urandom));
					set_regs(16'($urandom), 16'($urandom), 1'b1);
				end
				default: set_regs(16'($urandom), 16'($urandom), 1'b1);
			endcase
			if (ph == 0) begin
				// result side holds off while reads keep coming
				hold_request = 1'b1;
				gaps_on = 1'b0;
				repeat (40) random_read();
			end
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_end) begin
				gaps_on = ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 99);
				if (r < 60)
					send_packet(pick_mask(), 16'($urandom), $urandom_range(0, 99) < 8,
						$urandom_range(0, 99) < 15, $urandom_range(0, 9) == 0, 0, 10);
				else if (r < 72)
					send_packet(pick_mask(), 16'($urandom), 1'b0, 1'b0, 1'b0,
						$urandom_range(1, SMALL_BYTES - 1), 10);
				else if (r < 85)
					repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
				else if (sb.have_packet)
					repeat ($urandom_range(1, 6)) random_read();
			end
		end

		wait_idle();
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
